/* sv/bme_pkg.sv */
// shared types and constants of the block matrix encrypt datapath
package bme_pkg;

  localparam int ROWS = 5;
  localparam int KEY_BITS_DEFAULT = 9;
  localparam int CHAR_W = 8;
  localparam int PRODUCT_W = 20;
  localparam int ROW_W = $clog2(ROWS);
  localparam int CFG_IDX_W = $clog2(ROWS);
  localparam logic [CHAR_W-1:0] PAD_VALUE = CHAR_W'(5);

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              end_of_message;
  } item_t;

  typedef struct packed {
    logic signed [PRODUCT_W-1:0] product_0;
    logic signed [PRODUCT_W-1:0] product_1;
    logic signed [PRODUCT_W-1:0] product_2;
    logic signed [PRODUCT_W-1:0] product_3;
    logic signed [PRODUCT_W-1:0] product_4;
    logic                        last_column;
  } result_t;

  typedef struct packed {
    logic [ROWS-1:0][CHAR_W-1:0]    col;
    logic [ROWS-1:0][PRODUCT_W-1:0] sums;
    logic                           last;
  } col_t;

endpackage

/* sv/bme_front.sv */
// column assembler: gathers bytes into columns and issues padding columns
module bme_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  bme_pkg::item_t item,
  input  logic          chain_ready,
  output logic          col_valid,
  output bme_pkg::col_t col_out
);
  import bme_pkg::*;

  localparam int STORE_IDX_W = $clog2(ROWS - 1);

  logic [CHAR_W-1:0] col_store [ROWS-1];
  logic [ROW_W-1:0]  row_position;
  logic [ROW_W-1:0]  column_in_block;
  logic              flushing;

  logic accept;
  logic emit_byte;
  logic block_end;

  assign item_stall = flushing || !chain_ready;
  assign accept     = item_valid && !item_stall;
  assign emit_byte  = accept && (item.end_of_message || row_position == ROW_W'(ROWS - 1));
  assign block_end  = column_in_block == ROW_W'(ROWS - 1);
  assign col_valid  = emit_byte || (flushing && chain_ready);

  always_comb begin
    for (int i = 0; i < ROWS - 1; i++) begin
      if (flushing || ROW_W'(i) > row_position) begin
        col_out.col[i] = PAD_VALUE;
      end else if (ROW_W'(i) == row_position) begin
        col_out.col[i] = item.char_code;
      end else begin
        col_out.col[i] = col_store[i];
      end
    end
    if (!flushing && row_position == ROW_W'(ROWS - 1)) begin
      col_out.col[ROWS-1] = item.char_code;
    end else begin
      col_out.col[ROWS-1] = PAD_VALUE;
    end
    col_out.sums = '0;
    col_out.last = block_end && (flushing || item.end_of_message);
  end

  // open column bytes, read only where the current column wrote them
  always_ff @(posedge clk) begin
    if (accept && !emit_byte) begin
      col_store[row_position[STORE_IDX_W-1:0]] <= item.char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_position    <= '0;
      column_in_block <= '0;
      flushing        <= 1'b0;
    end else if (flushing) begin
      if (chain_ready) begin
        if (block_end) begin
          column_in_block <= '0;
          flushing        <= 1'b0;
        end else begin
          column_in_block <= column_in_block + ROW_W'(1);
        end
      end
    end else if (emit_byte) begin
      row_position <= '0;
      if (block_end) begin
        column_in_block <= '0;
      end else begin
        column_in_block <= column_in_block + ROW_W'(1);
        flushing        <= item.end_of_message;
      end
    end else if (accept) begin
      row_position <= row_position + ROW_W'(1);
    end
  end

endmodule

/* sv/bme_cell.sv */
// one multiply-add cell: adds key column times one column byte to every row sum
module bme_cell #(
  parameter int KEY_BITS = bme_pkg::KEY_BITS_DEFAULT,
  parameter int CELL     = 0
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [bme_pkg::ROWS-1:0][KEY_BITS-1:0] key_col,
  input  logic                                  up_valid,
  output logic                                  up_ready,
  input  bme_pkg::col_t                         up_pkt,
  output logic                                  down_valid,
  input  logic                                  down_ready,
  output bme_pkg::col_t                         down_pkt
);
  import bme_pkg::*;

  logic signed [KEY_BITS+CHAR_W:0] prod [ROWS];
  col_t                            pkt_next;

  assign up_ready = !down_valid || down_ready;

  always_comb begin
    pkt_next = up_pkt;
    for (int r = 0; r < ROWS; r++) begin
      prod[r] = $signed(key_col[r]) * $signed({1'b0, up_pkt.col[CELL]});
      pkt_next.sums[r] = up_pkt.sums[r] + PRODUCT_W'(prod[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (up_ready) begin
      down_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      down_pkt <= pkt_next;
    end
  end

endmodule

/* sv/block_matrix_encrypt.sv */
// top level: key registers, column assembler and the multiply-add cell chain
// One byte is taken per cycle unless the assembler is padding or the cell chain stalls.
// A column is issued when its last byte arrives and passes through a chain of five
// multiply-add cells, one per key column; the last cell is the output register. A byte
// marked end of message holds the input while the assembler issues up to four all-five
// columns to complete the block of five. Key registers are written through the
// configuration port; the user must do so only while no message is in flight, which the block does not enforce.
module block_matrix_encrypt #(
  parameter int KEY_BITS = bme_pkg::KEY_BITS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [bme_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [bme_pkg::ROWS*KEY_BITS-1:0]      cfg_data,
  input  logic                                   item_valid,
  output logic                                   item_stall,
  input  bme_pkg::item_t                         item,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output bme_pkg::result_t                       result
);
  import bme_pkg::*;

  logic [ROWS-1:0][ROWS*KEY_BITS-1:0] key_row;
  logic [ROWS-1:0][ROWS-1:0][KEY_BITS-1:0] key_col;

  logic [ROWS:0] stage_valid;
  logic [ROWS:0] stage_ready;
  col_t          stage_pkt [ROWS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_row <= '0;
    end else if (cfg_write && cfg_index < CFG_IDX_W'(ROWS)) begin
      key_row[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    for (int c = 0; c < ROWS; c++) begin
      for (int r = 0; r < ROWS; r++) begin
        key_col[c][r] = key_row[r][c*KEY_BITS +: KEY_BITS];
      end
    end
  end

  bme_front u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .chain_ready (stage_ready[0]),
    .col_valid   (stage_valid[0]),
    .col_out     (stage_pkt[0])
  );

  for (genvar c = 0; c < ROWS; c++) begin : g_cell
    bme_cell #(
      .KEY_BITS (KEY_BITS),
      .CELL     (c)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .key_col    (key_col[c]),
      .up_valid   (stage_valid[c]),
      .up_ready   (stage_ready[c]),
      .up_pkt     (stage_pkt[c]),
      .down_valid (stage_valid[c+1]),
      .down_ready (stage_ready[c+1]),
      .down_pkt   (stage_pkt[c+1])
    );
  end

  assign stage_ready[ROWS] = !result_stall;
  assign result_valid      = stage_valid[ROWS];

  always_comb begin
    result.product_0   = stage_pkt[ROWS].sums[0];
    result.product_1   = stage_pkt[ROWS].sums[1];
    result.product_2   = stage_pkt[ROWS].sums[2];
    result.product_3   = stage_pkt[ROWS].sums[3];
    result.product_4   = stage_pkt[ROWS].sums[4];
    result.last_column = stage_pkt[ROWS].last;
  end

`ifndef ASSERT_OFF
  a_issue_needs_room: assert property (@(posedge clk) disable iff (rst)
    stage_valid[0] |-> stage_ready[0])
    else $error("column issued into a full cell chain");

  a_bad_index_ignored: assert property (@(posedge clk) disable iff (rst)
    (cfg_write && cfg_index >= CFG_IDX_W'(ROWS)) |=> $stable(key_row))
    else $error("key changed by a write beyond the register list");

  a_end_holds_input: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && item.end_of_message && stage_valid[0]
     && !stage_pkt[0].last) |=> item_stall)
    else $error("input taken while padding columns remain");
`endif

endmodule
